// ===== rtl/derm_pkg.sv =====
// ----------------------------------------------------------------------------
// derm_pkg
// Shared types, constants and helpers for the debounced event rate meter:
// payload structs, register indexes, widths of the serial datapath.
// ----------------------------------------------------------------------------
package derm_pkg;

  // field widths
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RATE_W     = 22;
  localparam int unsigned QUAL_W     = 8;
  localparam int unsigned LOCK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // ring of event intervals and rate scale
  localparam int unsigned RING_DEPTH = 10;
  localparam int unsigned RATE_SCALE = 3600000;

  // serial datapath widths
  localparam int unsigned CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W     = TIME_W + CNT_W;
  localparam int unsigned DIV_W     = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [RATE_W-1:0] RATE_MAX       = {RATE_W{1'b1}};
  localparam logic [DIV_W-1:0]  RATE_SCALE_DIV = DIV_W'(RATE_SCALE);

  // register reset values
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(512);
  localparam logic [QUAL_W-1:0]  QUALIFY_RST   = QUAL_W'(2);
  localparam logic [LOCK_W-1:0]  LOCKOUT_RST   = LOCK_W'(2000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUALIFY_MS      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS      = CFG_IDX_W'(2);

  typedef struct packed {
    logic [LEVEL_W-1:0] sample_level;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic              event_counted;
    logic [RATE_W-1:0] rate_per_hour;
    logic              level_high;
  } out_item_t;

  // status of a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // saturate a quotient to the rate field
  function automatic logic [RATE_W-1:0] clamp_rate(input logic [DIV_W-1:0] q);
    logic [RATE_W-1:0] r;
    if (q > DIV_W'(RATE_MAX)) begin
      r = RATE_MAX;
    end else begin
      r = q[RATE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/debounced_event_rate_meter.sv =====
// ----------------------------------------------------------------------------
// debounced_event_rate_meter
// Sequence: a sample that counts no event or the first event goes straight to
// the done phase; one that pushes an interval waits for one ring rotation,
// then, unless the ring holds only zero intervals, for two passes of the
// bit-serial divider (mean of the ring, then scale over the mean).
// Flow: one sample at a time, next one accepted from the cycle the reading
// appears, later while the reading stalls.
// Reset: asynchronous, clears the ring, the event history, the held rate and
// loads the register defaults; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module debounced_event_rate_meter import derm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_RATE,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [LEVEL_W-1:0] threshold_q;
  logic [QUAL_W-1:0]  qualify_q;
  logic [LOCK_W-1:0]  lockout_q;
  logic               armed_q;
  logic [TIME_W-1:0]  window_end_q;
  logic               have_last_q;
  logic [TIME_W-1:0]  last_time_q;
  logic [RATE_W-1:0]  held_rate_q;
  logic               res_counted_q, res_high_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic               in_acc, out_free;
  logic               high, ended, do_arm, do_count, do_disarm;
  logic [TIME_W-1:0]  diff;
  logic               ring_push;
  logic [SUM_W-1:0]   ring_sum;
  logic [CNT_W-1:0]   ring_cnt;
  unit_stat_t         ring_stat;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [TIME_W-1:0]  div_divisor;
  logic [DIV_W-1:0]   div_quo;
  unit_stat_t         div_stat;
  logic [TIME_W-1:0]  mean;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // sample decision
  assign high      = in_data_i.sample_level > threshold_q;
  assign diff      = in_data_i.now_ms - window_end_q;
  assign ended     = (diff != '0) && !diff[TIME_W-1];
  assign do_arm    = ended && !armed_q && high;
  assign do_count  = ended && armed_q && high;
  assign do_disarm = ended && armed_q && !high;
  assign ring_push = in_acc && do_count && have_last_q;

  assign mean = div_quo[TIME_W-1:0];

  // divider requests: mean of the ring, then scale over the mean
  always_comb begin
    div_start    = 1'b0;
    div_dividend = ring_sum;
    div_divisor  = TIME_W'(ring_cnt);
    unique case (state_q)
      ST_SUM: begin
        div_start = ring_stat.done && (ring_cnt != '0);
      end
      ST_MEAN: begin
        div_start    = div_stat.done && (mean != '0);
        div_dividend = RATE_SCALE_DIV;
        div_divisor  = mean;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      qualify_q   <= QUALIFY_RST;
      lockout_q   <= LOCKOUT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_LEVEL_THRESHOLD) begin
        threshold_q <= cfg_data_i[LEVEL_W-1:0];
      end
      if (cfg_index_i == CFG_QUALIFY_MS) begin
        qualify_q <= cfg_data_i[QUAL_W-1:0];
      end
      if (cfg_index_i == CFG_LOCKOUT_MS) begin
        lockout_q <= cfg_data_i[LOCK_W-1:0];
      end
    end
  end

  // sequencer, event state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      armed_q       <= 1'b0;
      window_end_q  <= '0;
      have_last_q   <= 1'b0;
      last_time_q   <= '0;
      held_rate_q   <= '0;
      res_counted_q <= 1'b0;
      res_high_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      // reading taken; the done phase loads the next one itself
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_counted_q <= do_count;
            res_high_q    <= high;
            state_q       <= ring_push ? ST_SUM : ST_DONE;
            if (do_arm) begin
              armed_q      <= 1'b1;
              window_end_q <= in_data_i.now_ms + TIME_W'(qualify_q);
            end else if (do_count) begin
              window_end_q <= in_data_i.now_ms + TIME_W'(lockout_q);
              last_time_q  <= in_data_i.now_ms;
              if (!have_last_q) begin
                have_last_q <= 1'b1;
                held_rate_q <= RATE_W'(1);
              end
            end else if (do_disarm) begin
              armed_q      <= 1'b0;
              window_end_q <= in_data_i.now_ms - TIME_W'(1);
            end
          end
        end
        ST_SUM: begin
          if (ring_stat.done) begin
            if (ring_cnt == '0) begin
              held_rate_q <= clamp_rate(RATE_SCALE_DIV);
              state_q     <= ST_DONE;
            end else begin
              state_q <= ST_MEAN;
            end
          end
        end
        ST_MEAN: begin
          if (div_stat.done) begin
            if (mean == '0) begin
              held_rate_q <= clamp_rate(RATE_SCALE_DIV);
              state_q     <= ST_DONE;
            end else begin
              state_q <= ST_RATE;
            end
          end
        end
        ST_RATE: begin
          if (div_stat.done) begin
            held_rate_q <= clamp_rate(div_quo);
            state_q     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q                <= 1'b1;
            out_data_q.event_counted   <= res_counted_q;
            out_data_q.rate_per_hour   <= held_rate_q;
            out_data_q.level_high      <= res_high_q;
            state_q                    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  derm_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ring_push),
    .push_data_i (in_data_i.now_ms - last_time_q),
    .sum_o       (ring_sum),
    .cnt_o       (ring_cnt),
    .stat_o      (ring_stat)
  );

  derm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the divider is never restarted while a division runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // the ring is never pushed while it rotates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_push |-> !ring_stat.busy)
    else $error("ring pushed while rotating");

  // ring results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_stat.done |-> state_q == ST_SUM)
    else $error("ring finished outside the sum phase");

  // divider results only arrive in the two division phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_MEAN || state_q == ST_RATE))
    else $error("divider finished outside a division phase");

  // a counted event always leaves an event history behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.event_counted) |-> have_last_q)
    else $error("event reported without event history");

endmodule

// ===== rtl/derm_ring.sv =====
// ----------------------------------------------------------------------------
// derm_ring
// Ring of the last event intervals as a shift line. A push shifts in a new
// interval, then the line rotates once round, one entry per cycle, summing
// the nonzero entries and counting them.
// ----------------------------------------------------------------------------
module derm_ring import derm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [TIME_W-1:0] push_data_i,
  output logic [SUM_W-1:0]  sum_o,
  output logic [CNT_W-1:0]  cnt_o,
  output unit_stat_t        stat_o
);

  logic [TIME_W-1:0] ring_q [RING_DEPTH];
  logic              busy_q, done_q;
  logic [CNT_W-1:0]  step_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] tail;

  assign tail = ring_q[RING_DEPTH-1];

  // shift in on push, then one full rotation accumulating the tail
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_q[k] <= '0;
      end
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (push_i) begin
        ring_q[0] <= push_data_i;
        for (int k = 1; k < RING_DEPTH; k++) begin
          ring_q[k] <= ring_q[k-1];
        end
        busy_q <= 1'b1;
        step_q <= CNT_W'(RING_DEPTH);
        sum_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (tail != '0) begin
          sum_q <= sum_q + SUM_W'(tail);
          cnt_q <= cnt_q + CNT_W'(1);
        end
        ring_q[0] <= tail;
        for (int k = 1; k < RING_DEPTH; k++) begin
          ring_q[k] <= ring_q[k-1];
        end
        step_q <= step_q - CNT_W'(1);
        if (step_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sum_o       = sum_q;
  assign cnt_o       = cnt_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/derm_div.sv =====
// ----------------------------------------------------------------------------
// derm_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend bits
// shifting out of the top of the quotient register as quotient bits enter.
// ----------------------------------------------------------------------------
module derm_div import derm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [TIME_W-1:0] divisor_i,
  output logic [DIV_W-1:0]  quotient_o,
  output unit_stat_t        stat_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TIME_W-1:0]    rem_q, dvs_q;
  logic [DIV_W-1:0]     quo_q;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 fits;

  // one restoring step
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== verif/tb_debounced_event_rate_meter.sv =====
// ----------------------------------------------------------------------------
// tb_debounced_event_rate_meter
// Self-checking bench for the debounced event rate meter. A scoreboard model
// tracks arming, qualify and lockout windows, the interval ring and the held
// rate, and every reading is compared against it field by field. A short
// directed run hits boundaries, wrap-around and zero intervals; random pulse
// trains follow under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_debounced_event_rate_meter;
  timeunit 1ns;
  timeprecision 1ps;
  import derm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned TAIL_CYCLES = 100;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  // block interface
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  debounced_event_rate_meter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // stimulus and scoreboard stores
  in_item_t  sample_q [$];
  out_item_t due_readings [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_events  = 0;
  int unsigned n_cfg     = 0;
  int unsigned n_bad     = 0;

  logic [TIME_W-1:0] t_now = '0;

  // meter model: registers and state
  logic [LEVEL_W-1:0] pr_thr;
  logic [QUAL_W-1:0]  pr_qual;
  logic [LOCK_W-1:0]  pr_lock;
  logic               pr_armed;
  logic [TIME_W-1:0]  pr_window_end;
  logic               pr_have_last;
  logic [TIME_W-1:0]  pr_last_t;
  logic [TIME_W-1:0]  pr_gaps [RING_DEPTH];
  logic [RATE_W-1:0]  pr_rate;

  // one sample through the meter model, returns the reading it produces
  function automatic out_item_t rate_reading(input in_item_t s);
    out_item_t         r;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] mean;
    logic [63:0]       total;
    logic [63:0]       quo;
    int unsigned       used;
    logic              high;
    logic              ended;
    logic              counted;
    high    = s.sample_level > pr_thr;
    since   = s.now_ms - pr_window_end;
    ended   = (since != '0) && !since[TIME_W-1];
    counted = 1'b0;
    if (ended) begin
      if (!pr_armed && high) begin
        // rising level opens the qualify window
        pr_armed      = 1'b1;
        pr_window_end = s.now_ms + TIME_W'(pr_qual);
      end else if (pr_armed && high) begin
        counted = 1'b1;
        if (!pr_have_last) begin
          pr_rate      = RATE_W'(1);
          pr_have_last = 1'b1;
        end else begin
          // shift the interval into the ring, average the nonzero slots
          for (int k = RING_DEPTH - 1; k >= 1; k--) begin
            pr_gaps[k] = pr_gaps[k-1];
          end
          pr_gaps[0] = s.now_ms - pr_last_t;
          total = '0;
          used  = 0;
          foreach (pr_gaps[k]) begin
            if (pr_gaps[k] != '0) begin
              total += 64'(pr_gaps[k]);
              used++;
            end
          end
          mean    = (used == 0) ? '0 : TIME_W'(total / 64'(used));
          quo     = (mean == '0) ? 64'(RATE_SCALE) : 64'(RATE_SCALE) / 64'(mean);
          pr_rate = (quo > 64'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
        end
        pr_last_t     = s.now_ms;
        pr_window_end = s.now_ms + TIME_W'(pr_lock);
      end else if (pr_armed && !high) begin
        // falling level disarms, next sample sees the window as ended
        pr_armed      = 1'b0;
        pr_window_end = s.now_ms - TIME_W'(1);
      end
    end
    r.event_counted = counted;
    r.rate_per_hour = pr_rate;
    r.level_high    = high;
    return r;
  endfunction

  // request driver: feeds samples from the queue, predicts on acceptance
  always @(posedge clk or negedge rst_n) begin : req_driver
    logic held;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      held = in_valid;
      if (in_valid && in_ready) begin
        due_readings.push_back(rate_reading(in_data));
        n_sent++;
        if (due_readings[$].event_counted) begin
          n_events++;
        end
        held = 1'b0;
      end
      if (!held) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reading monitor: checks every accepted reading against the oldest due one
  always @(posedge clk or negedge rst_n) begin : rd_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_readings.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("unexpected reading: ev=%0b rate=%0d high=%0b",
                     out_data.event_counted, out_data.rate_per_hour, out_data.level_high);
          end
        end else begin
          want = due_readings.pop_front();
          if (out_data.event_counted !== want.event_counted ||
              out_data.rate_per_hour !== want.rate_per_hour ||
              out_data.level_high !== want.level_high) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("reading %0d: want ev=%0b rate=%0d high=%0b, got ev=%0b rate=%0d high=%0b",
                       n_checked, want.event_counted, want.rate_per_hour, want.level_high,
                       out_data.event_counted, out_data.rate_per_hour, out_data.level_high);
            end
          end
        end
        n_checked++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_sample(input logic [LEVEL_W-1:0] lvl, input logic [TIME_W-1:0] t);
    in_item_t s;
    s.sample_level = lvl;
    s.now_ms       = t;
    sample_q.push_back(s);
  endtask

  // wait until every request is accepted and every reading is back
  task automatic settle();
    while (sample_q.size() != 0 || in_valid || due_readings.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // register write, only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEVEL_THRESHOLD: pr_thr  = val[LEVEL_W-1:0];
      CFG_QUALIFY_MS:      pr_qual = val[QUAL_W-1:0];
      CFG_LOCKOUT_MS:      pr_lock = val[LOCK_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] hi_level();
    if (pr_thr == '1) begin
      return '1;
    end
    return LEVEL_W'($urandom_range(int'(pr_thr) + 1, 1023));
  endfunction

  function automatic logic [LEVEL_W-1:0] lo_level();
    return LEVEL_W'($urandom_range(0, int'(pr_thr)));
  endfunction

  // walk time round the 32-bit wrap so the next event lands on the exact
  // stamp of the previous one, giving a zero interval
  task automatic revisit_last_event(output int unsigned made);
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] t;
    made = 0;
    settle();
    if (!pr_have_last) begin
      return;
    end
    d = pr_last_t - pr_window_end + TIME_W'(1) - TIME_W'(pr_qual);
    t = pr_window_end;
    if (pr_armed) begin
      if (d < 3) begin
        return;
      end
      a = d / 3;
      t = t + a;
      push_sample(lo_level(), t);
      t = t - TIME_W'(1) + a;
      made = 1;
    end else begin
      if (d < 3) begin
        return;
      end
      b = (d - TIME_W'(1)) / 2;
      t = t + b;
    end
    push_sample(hi_level(), t);
    push_sample(hi_level(), pr_last_t);
    t_now = pr_last_t;
    made  = made + 2;
  endtask

  // random pulse trains with noise, jumps and zero-interval revisits
  task automatic random_phase(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned reps;
    int unsigned extra;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // low lead-in, rising edge, held high through the qualify window
        reps = $urandom_range(1, 3);
        for (int k = 0; k < reps; k++) begin
          t_now += TIME_W'($urandom_range(1, 4));
          push_sample(lo_level(), t_now);
        end
        t_now += TIME_W'($urandom_range(1, 3));
        push_sample(hi_level(), t_now);
        made += reps + 1;
        reps = $urandom_range(1, 4);
        for (int k = 0; k < reps; k++) begin
          t_now += TIME_W'($urandom_range(0, int'(pr_qual) / 2 + 2));
          push_sample(hi_level(), t_now);
        end
        made += reps;
        // sometimes held past the lockout for a repeat count
        if ($urandom_range(0, 3) == 0) begin
          t_now += TIME_W'(pr_lock) + TIME_W'($urandom_range(1, 3));
          push_sample(hi_level(), t_now);
          made++;
        end
        t_now += TIME_W'($urandom_range(0, int'(pr_lock) + 2));
        push_sample(lo_level(), t_now);
        made++;
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 1) begin
          t_now = $urandom();
        end else begin
          t_now += TIME_W'($urandom_range(0, 3));
        end
        push_sample(LEVEL_W'($urandom_range(0, 1023)), t_now);
        made++;
      end else if (pick < 96) begin
        // large jump, past half the range counts as going backwards
        t_now += TIME_W'($urandom_range(0, 32'h9000_0000));
        push_sample($urandom_range(0, 1) ? hi_level() : lo_level(), t_now);
        made++;
      end else begin
        revisit_last_event(extra);
        made += extra;
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [QUAL_W-1:0] q;
    logic [LOCK_W-1:0] l;
    settle();
    q = ($urandom_range(0, 3) == 0) ? QUAL_W'($urandom_range(0, 255))
                                    : QUAL_W'($urandom_range(0, 5));
    l = ($urandom_range(0, 3) == 0) ? LOCK_W'($urandom_range(0, 65535))
                                    : LOCK_W'($urandom_range(0, 40));
    // upper bits random to exercise masking
    write_reg(CFG_LEVEL_THRESHOLD, {6'($urandom()), LEVEL_W'($urandom_range(1, 1022))});
    write_reg(CFG_QUALIFY_MS, {8'($urandom()), q});
    write_reg(CFG_LOCKOUT_MS, l);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if ($urandom_range(0, 1) == 1) begin
      t_now = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 200));
    end
    random_phase(PHASE_ITEMS);
  endtask

  // run-time limit
  initial begin
    #20_000_000;
    $display("debounced_event_rate_meter: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned made;
    pr_thr        = THRESHOLD_RST;
    pr_qual       = QUALIFY_RST;
    pr_lock       = LOCKOUT_RST;
    pr_armed      = 1'b0;
    pr_window_end = '0;
    pr_have_last  = 1'b0;
    pr_last_t     = '0;
    pr_rate       = '0;
    foreach (pr_gaps[k]) begin
      pr_gaps[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: time zero right after reset, threshold boundary,
    // first event
    push_sample(10'd1023, 32'd0);
    push_sample(10'd512, 32'd1);
    push_sample(10'd513, 32'd2);
    push_sample(10'd700, 32'd4);
    push_sample(10'd700, 32'd5);
    // zero interval with an otherwise empty ring sets the rate to RATE_SCALE
    revisit_last_event(made);
    // level held high through two lockouts, then falling
    push_sample(10'd900, 32'd2006);
    push_sample(10'd900, 32'd4006);
    push_sample(10'd900, 32'd4007);
    push_sample(10'd100, 32'd6008);
    push_sample(10'd100, 32'd6009);
    settle();

    // lowest settings, masked upper bits, write to the spare index ignored
    write_reg(CFG_LEVEL_THRESHOLD, 16'hFC00);
    write_reg(CFG_QUALIFY_MS, 16'hFF00);
    write_reg(CFG_LOCKOUT_MS, 16'h0000);
    write_reg(CFG_SPARE, 16'hFFFF);
    push_sample(10'd0, 32'd6020);
    push_sample(10'd1, 32'd6021);
    push_sample(10'd1, 32'd6021);
    push_sample(10'd1, 32'd6022);
    push_sample(10'd1, 32'd6023);
    push_sample(10'd0, 32'd6024);
    settle();

    // highest settings: nothing can exceed the threshold
    write_reg(CFG_LEVEL_THRESHOLD, 16'hFFFF);
    write_reg(CFG_QUALIFY_MS, 16'h00FF);
    write_reg(CFG_LOCKOUT_MS, 16'hFFFF);
    write_reg(CFG_SPARE, 16'h0000);
    push_sample(10'd1023, 32'd6030);
    push_sample(10'd0, 32'hFFFF_FFFF);
    t_now = 32'd6040;

    // random phases: free flow, sender idle, receiver stalling, both
    run_phase(0, 0);
    run_phase(74, 0);
    run_phase(0, 74);
    run_phase(33, 33);

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("%0d samples over %0d register writes, %0d events counted", n_sent, n_cfg,
             n_events);
    $display("%0d readings checked, %0d mismatches", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("debounced_event_rate_meter: match");
    end else begin
      $display("debounced_event_rate_meter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/derm_pkg.sv
rtl/derm_ring.sv
rtl/derm_div.sv
rtl/debounced_event_rate_meter.sv
verif/tb_debounced_event_rate_meter.sv
